// ===== hw/rtl/cac_pkg.sv =====
`timescale 1ns / 1ps

package cac_pkg;

    localparam int unsigned TAG_W      = 30;
    localparam int unsigned STAMP_W    = 32;
    localparam int unsigned STAT_W     = 48;
    localparam int unsigned CYC_W      = 14;
    localparam int unsigned BLK_W      = 13;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;
    localparam int unsigned WORD_COST  = 100;
    localparam int unsigned MIN_OFF    = 2;
    localparam int unsigned MAX_OFF    = 8;
    localparam int unsigned NUM_STATS  = 7;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    localparam logic [1:0] WP_ALLOC_THROUGH   = 2'd0;
    localparam logic [1:0] WP_ALLOC_BACK      = 2'd1;
    localparam logic [1:0] WP_NOALLOC_THROUGH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_POLICY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LRU  = 2'd3;

    localparam int unsigned CNT_LOAD       = 0;
    localparam int unsigned CNT_STORE      = 1;
    localparam int unsigned CNT_LOAD_HIT   = 2;
    localparam int unsigned CNT_LOAD_MISS  = 3;
    localparam int unsigned CNT_STORE_HIT  = 4;
    localparam int unsigned CNT_STORE_MISS = 5;
    localparam int unsigned CNT_CYCLES     = 6;

    typedef struct packed {
        logic               store;
        logic [TAG_W-1:0]   tag;
        logic [BLK_W-1:0]   blk_cost;
    } req_info_t;

    typedef struct packed {
        logic               valid;
        logic               dirty;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] fill_stamp;
        logic [STAMP_W-1:0] use_stamp;
    } way_t;

    typedef struct packed {
        logic [3:0] block_offset_bits;
        logic [3:0] set_index_bits;
        logic [1:0] write_policy;
        logic       replace_lru;
    } cfg_t;

    function automatic logic [STAT_W-1:0] sat_add(
        input logic [STAT_W-1:0] c,
        input logic [STAT_W-1:0] v
    );
        logic [STAT_W:0] s;
        s = {1'b0, c} + {1'b0, v};
        return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/cac_front.sv =====
`timescale 1ns / 1ps

module cac_front #(
    parameter int unsigned NUM_SETS = 256
) (
    input  cac_pkg::cfg_t                            cfg,
    input  logic                                     opcode,
    input  logic [31:0]                              address,
    output logic [(NUM_SETS > 1 ? $clog2(NUM_SETS) : 1)-1:0] set_idx,
    output cac_pkg::req_info_t                       info
);

    localparam int unsigned SW    = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
    localparam int unsigned MAXIB = $clog2(NUM_SETS + 1) - 1;

    logic [3:0]  off;
    logic [3:0]  ib;
    logic [31:0] set_full;
    logic [31:0] tag_full;

    always_comb
    begin
        if (cfg.block_offset_bits < 4'(cac_pkg::MIN_OFF))
            off = 4'(cac_pkg::MIN_OFF);
        else if (cfg.block_offset_bits > 4'(cac_pkg::MAX_OFF))
            off = 4'(cac_pkg::MAX_OFF);
        else
            off = cfg.block_offset_bits;
        ib = (cfg.set_index_bits > 4'(MAXIB)) ? 4'(MAXIB) : cfg.set_index_bits;
        set_full = (address >> off) & ((32'd1 << ib) - 32'd1);
        tag_full = address >> (5'(off) + 5'(ib));
        set_idx = set_full[SW-1:0];
        info.store = (opcode == cac_pkg::OP_STORE);
        info.tag = tag_full[cac_pkg::TAG_W-1:0];
        info.blk_cost = cac_pkg::BLK_W'(cac_pkg::WORD_COST) << 3'(off - 4'(cac_pkg::MIN_OFF));
    end

endmodule

// ===== hw/rtl/cac_queue.sv =====
`timescale 1ns / 1ps

module cac_queue #(
    parameter int unsigned DW = 44
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output logic [DW-1:0] pop_data
);

    logic [DW-1:0] entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== hw/rtl/cac_back.sv =====
`timescale 1ns / 1ps

module cac_back #(
    parameter int unsigned NUM_SETS = 256,
    parameter int unsigned NUM_WAYS = 4
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  cac_pkg::cfg_t                            cfg,
    input  logic                                     q_valid,
    input  logic [(NUM_SETS > 1 ? $clog2(NUM_SETS) : 1)-1:0] q_set,
    input  cac_pkg::req_info_t                       q_info,
    output logic                                     q_pop,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     was_hit,
    output logic                                     dirty_evicted,
    output logic [cac_pkg::CYC_W-1:0]                access_cycles,
    output logic [cac_pkg::STAT_W-1:0]               stat [cac_pkg::NUM_STATS]
);

    localparam int unsigned SW = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
    localparam int unsigned WW = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EVAL} state_t;
    typedef cac_pkg::way_t [NUM_WAYS-1:0] row_t;

    row_t row_mem [NUM_SETS];

    state_t                         state_reg;
    logic [SW-1:0]                  clr_reg;
    logic [SW-1:0]                  cur_set_reg;
    cac_pkg::req_info_t             cur_reg;
    row_t                           rd_row_reg;
    logic [cac_pkg::STAMP_W-1:0]    clock_reg;
    logic [cac_pkg::STAT_W-1:0]     cnt_reg [cac_pkg::NUM_STATS];
    logic                           out_valid_reg;
    logic                           hit_reg;
    logic                           devict_reg;
    logic [cac_pkg::CYC_W-1:0]      cycles_reg;

    logic                           slot_free;
    logic                           commit;
    logic                           mem_we;
    logic [SW-1:0]                  mem_addr;
    row_t                           row_next;
    logic [cac_pkg::STAMP_W-1:0]    clock_next;
    logic                           hit;
    logic                           devict;
    logic [cac_pkg::CYC_W-1:0]      cycles;
    logic [WW-1:0]                  hit_way;
    logic [WW-1:0]                  inv_way;
    logic [WW-1:0]                  lru_way;
    logic [WW-1:0]                  way;
    logic                           found_inv;
    logic [cac_pkg::STAMP_W-1:0]    best;
    logic [cac_pkg::STAMP_W-1:0]    s;
    logic                           wback;
    logic                           alloc;
    logic                           fill;
    logic [cac_pkg::CYC_W-1:0]      blk;

    assign slot_free     = !out_valid_reg || out_ready;
    assign commit        = (state_reg == S_EVAL) && slot_free;
    assign q_pop         = (state_reg == S_IDLE) && q_valid;
    assign out_valid     = out_valid_reg;
    assign was_hit       = hit_reg;
    assign dirty_evicted = devict_reg;
    assign access_cycles = cycles_reg;
    assign stat          = cnt_reg;

    always_comb
    begin
        wback = (cfg.write_policy == cac_pkg::WP_ALLOC_BACK);
        alloc = (cfg.write_policy == cac_pkg::WP_ALLOC_THROUGH) || wback;
        blk = cac_pkg::CYC_W'(cur_reg.blk_cost);
        clock_next = clock_reg + 32'd1;
        hit = 1'b0;
        hit_way = '0;
        found_inv = 1'b0;
        inv_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (rd_row_reg[w].valid && rd_row_reg[w].tag == cur_reg.tag)
            begin
                hit = 1'b1;
                hit_way = WW'(w);
            end
            if (!rd_row_reg[w].valid)
            begin
                found_inv = 1'b1;
                inv_way = WW'(w);
            end
        end
        best = cfg.replace_lru ? rd_row_reg[0].use_stamp : rd_row_reg[0].fill_stamp;
        lru_way = '0;
        for (int w = 1; w < NUM_WAYS; w++)
        begin
            s = cfg.replace_lru ? rd_row_reg[w].use_stamp : rd_row_reg[w].fill_stamp;
            if (s < best)
            begin
                best = s;
                lru_way = WW'(w);
            end
        end
        row_next = rd_row_reg;
        devict = 1'b0;
        fill = 1'b0;
        way = hit ? hit_way : (found_inv ? inv_way : lru_way);
        if (hit)
        begin
            cycles = 14'd1;
            if (cur_reg.store)
            begin
                if (wback)
                    row_next[way].dirty = 1'b1;
                else
                    cycles = cycles + 14'(cac_pkg::WORD_COST);
            end
            row_next[way].use_stamp = clock_next;
        end
        else if (cur_reg.store && !alloc)
        begin
            cycles = 14'(cac_pkg::WORD_COST + 1);
        end
        else
        begin
            fill = 1'b1;
            cycles = 14'd1 + blk;
            if (!found_inv && rd_row_reg[way].dirty)
            begin
                devict = 1'b1;
                cycles = cycles + blk;
            end
        end
        if (fill)
        begin
            row_next[way].valid = 1'b1;
            row_next[way].tag = cur_reg.tag;
            row_next[way].use_stamp = clock_next;
            row_next[way].fill_stamp = clock_next;
            row_next[way].dirty = cur_reg.store && wback;
            if (cur_reg.store && !wback)
                cycles = cycles + 14'(cac_pkg::WORD_COST);
        end
        if (state_reg == S_CLEAR)
        begin
            row_next = '0;
            mem_we = 1'b1;
            mem_addr = clr_reg;
        end
        else
        begin
            mem_we = commit;
            mem_addr = cur_set_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[mem_addr] <= row_next;
        if (q_pop)
        begin
            rd_row_reg  <= row_mem[q_set];
            cur_reg     <= q_info;
            cur_set_reg <= q_set;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            clock_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            devict_reg    <= 1'b0;
            cycles_reg    <= '0;
            for (int i = 0; i < cac_pkg::NUM_STATS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !commit)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SW'(NUM_SETS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (slot_free)
                    begin
                        state_reg     <= S_IDLE;
                        clock_reg     <= clock_next;
                        out_valid_reg <= 1'b1;
                        hit_reg       <= hit;
                        devict_reg    <= devict;
                        cycles_reg    <= cycles;
                        if (cur_reg.store)
                        begin
                            cnt_reg[cac_pkg::CNT_STORE] <=
                                cac_pkg::sat_add(cnt_reg[cac_pkg::CNT_STORE], 48'd1);
                            if (hit)
                                cnt_reg[cac_pkg::CNT_STORE_HIT] <=
                                    cac_pkg::sat_add(cnt_reg[cac_pkg::CNT_STORE_HIT], 48'd1);
                            else
                                cnt_reg[cac_pkg::CNT_STORE_MISS] <=
                                    cac_pkg::sat_add(cnt_reg[cac_pkg::CNT_STORE_MISS], 48'd1);
                        end
                        else
                        begin
                            cnt_reg[cac_pkg::CNT_LOAD] <=
                                cac_pkg::sat_add(cnt_reg[cac_pkg::CNT_LOAD], 48'd1);
                            if (hit)
                                cnt_reg[cac_pkg::CNT_LOAD_HIT] <=
                                    cac_pkg::sat_add(cnt_reg[cac_pkg::CNT_LOAD_HIT], 48'd1);
                            else
                                cnt_reg[cac_pkg::CNT_LOAD_MISS] <=
                                    cac_pkg::sat_add(cnt_reg[cac_pkg::CNT_LOAD_MISS], 48'd1);
                        end
                        cnt_reg[cac_pkg::CNT_CYCLES] <=
                            cac_pkg::sat_add(cnt_reg[cac_pkg::CNT_CYCLES], 48'(cycles));
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/set_assoc_cache_controller.sv =====
`timescale 1ns / 1ps

// set-associative cache controller, LRU or FIFO replacement, write-back or through
// input channel (in_valid/in_ready): opcode (0 load, 1 store) and a 32-bit byte address
// output channel (out_valid/out_ready): hit, dirty eviction, cycles of this access
//   and the running saturating statistics after this access
// configuration: cfg_write_en with cfg_index/cfg_data, only while the block is idle
// the front decodes set and tag into a two-entry queue; the back reads the set's
// row from the tag memory into a register, then evaluates it and writes it back once
// the output register is free; the back takes the next access from the queue only
// after that write back, so an access passes the queue, row and output registers
// after reset a clearing pass over all NUM_SETS rows empties the tag memory; inputs are
//   queued meanwhile but no access is processed until it ends
// a stalled receiver holds the result in the output register; the back waits with
//   the next access and the queue fills, then in_ready drops
module set_assoc_cache_controller #(
    parameter int unsigned NUM_SETS = 256,
    parameter int unsigned NUM_WAYS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [cac_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cac_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic [31:0]                         address,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                was_hit,
    output logic                                dirty_evicted,
    output logic [cac_pkg::CYC_W-1:0]           access_cycles,
    output logic [cac_pkg::STAT_W-1:0]          load_count,
    output logic [cac_pkg::STAT_W-1:0]          store_count,
    output logic [cac_pkg::STAT_W-1:0]          load_hit_count,
    output logic [cac_pkg::STAT_W-1:0]          load_miss_count,
    output logic [cac_pkg::STAT_W-1:0]          store_hit_count,
    output logic [cac_pkg::STAT_W-1:0]          store_miss_count,
    output logic [cac_pkg::STAT_W-1:0]          cycle_total
);

    localparam int unsigned SW = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
    localparam int unsigned DW = SW + $bits(cac_pkg::req_info_t);

    cac_pkg::cfg_t              cfg_reg;
    logic [SW-1:0]              f_set;
    cac_pkg::req_info_t         f_info;
    logic                       q_full;
    logic                       q_valid;
    logic                       q_pop;
    logic [DW-1:0]              q_data;
    logic                       push;
    logic [cac_pkg::STAT_W-1:0] stat [cac_pkg::NUM_STATS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_offset_bits <= 4'd4;
            cfg_reg.set_index_bits    <= 4'd8;
            cfg_reg.write_policy      <= cac_pkg::WP_ALLOC_BACK;
            cfg_reg.replace_lru       <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                cac_pkg::CFG_BLOCK_OFFSET: cfg_reg.block_offset_bits <= cfg_data;
                cac_pkg::CFG_SET_INDEX:    cfg_reg.set_index_bits    <= cfg_data;
                cac_pkg::CFG_WRITE_POLICY: cfg_reg.write_policy      <= cfg_data[1:0];
                cac_pkg::CFG_REPLACE_LRU:  cfg_reg.replace_lru       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    cac_front #(.NUM_SETS(NUM_SETS)) u_front (
        .cfg     (cfg_reg),
        .opcode  (opcode),
        .address (address),
        .set_idx (f_set),
        .info    (f_info)
    );

    cac_queue #(.DW(DW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_set, f_info}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    cac_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_set         (q_data[DW-1 -: SW]),
        .q_info        (cac_pkg::req_info_t'(q_data[DW-SW-1:0])),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .was_hit       (was_hit),
        .dirty_evicted (dirty_evicted),
        .access_cycles (access_cycles),
        .stat          (stat)
    );

    assign load_count       = stat[cac_pkg::CNT_LOAD];
    assign store_count      = stat[cac_pkg::CNT_STORE];
    assign load_hit_count   = stat[cac_pkg::CNT_LOAD_HIT];
    assign load_miss_count  = stat[cac_pkg::CNT_LOAD_MISS];
    assign store_hit_count  = stat[cac_pkg::CNT_STORE_HIT];
    assign store_miss_count = stat[cac_pkg::CNT_STORE_MISS];
    assign cycle_total      = stat[cac_pkg::CNT_CYCLES];

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int unsigned SETS = 256;
    localparam int unsigned WAYS = 4;
    localparam int unsigned IDX_MAX = 8;
    localparam logic [cac_pkg::STAT_W-1:0] STAT_SAT = {cac_pkg::STAT_W{1'b1}};

    typedef struct packed {
        logic        op;
        logic [31:0] addr;
    } access_t;

    typedef struct packed {
        logic                       hit;
        logic                       devict;
        logic [cac_pkg::CYC_W-1:0]  cyc;
        logic [cac_pkg::STAT_W-1:0] n_load;
        logic [cac_pkg::STAT_W-1:0] n_store;
        logic [cac_pkg::STAT_W-1:0] n_load_hit;
        logic [cac_pkg::STAT_W-1:0] n_load_miss;
        logic [cac_pkg::STAT_W-1:0] n_store_hit;
        logic [cac_pkg::STAT_W-1:0] n_store_miss;
        logic [cac_pkg::STAT_W-1:0] n_cycles;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [cac_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cac_pkg::CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic opcode;
    logic [31:0] address;
    logic out_valid;
    logic out_ready;
    logic was_hit;
    logic dirty_evicted;
    logic [cac_pkg::CYC_W-1:0] access_cycles;
    logic [cac_pkg::STAT_W-1:0] load_count;
    logic [cac_pkg::STAT_W-1:0] store_count;
    logic [cac_pkg::STAT_W-1:0] load_hit_count;
    logic [cac_pkg::STAT_W-1:0] load_miss_count;
    logic [cac_pkg::STAT_W-1:0] store_hit_count;
    logic [cac_pkg::STAT_W-1:0] store_miss_count;
    logic [cac_pkg::STAT_W-1:0] cycle_total;

    set_assoc_cache_controller dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .address(address),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .was_hit(was_hit),
        .dirty_evicted(dirty_evicted),
        .access_cycles(access_cycles),
        .load_count(load_count),
        .store_count(store_count),
        .load_hit_count(load_hit_count),
        .load_miss_count(load_miss_count),
        .store_hit_count(store_hit_count),
        .store_miss_count(store_miss_count),
        .cycle_total(cycle_total)
    );

    // cache model state
    logic [3:0] m_off_bits;
    logic [3:0] m_idx_bits;
    logic [1:0] m_policy;
    logic       m_lru;
    logic [cac_pkg::TAG_W-1:0]   m_tag   [SETS*WAYS];
    logic                        m_valid [SETS*WAYS];
    logic                        m_dirty [SETS*WAYS];
    logic [cac_pkg::STAMP_W-1:0] m_fill  [SETS*WAYS];
    logic [cac_pkg::STAMP_W-1:0] m_use   [SETS*WAYS];
    logic [cac_pkg::STAMP_W-1:0] m_clock;
    logic [cac_pkg::STAT_W-1:0]  m_stat  [cac_pkg::NUM_STATS];

    access_t  pending_accesses[$];
    outcome_t expected_outcomes[$];
    int mismatches;
    bit hold_off;
    bit accepted_now;

    function automatic logic [cac_pkg::STAT_W-1:0] stat_inc(
        logic [cac_pkg::STAT_W-1:0] c,
        logic [cac_pkg::STAT_W-1:0] v
    );
        logic [cac_pkg::STAT_W:0] s;
        s = {1'b0, c} + {1'b0, v};
        return s[cac_pkg::STAT_W] ? STAT_SAT : s[cac_pkg::STAT_W-1:0];
    endfunction

    function automatic outcome_t cache_access(access_t a);
        outcome_t r;
        int unsigned off;
        int unsigned ib;
        int unsigned set_no;
        int unsigned base;
        int unsigned way;
        int unsigned blk;
        int unsigned cyc;
        int unsigned k_cnt;
        logic [31:0] tag;
        logic [31:0] best;
        logic [31:0] s;
        bit hit;
        bit devict;
        bit fill;
        bit found;
        bit alloc;
        bit wback;
        bit is_store;
        off = m_off_bits < 4'd2 ? 2 : (m_off_bits > 4'd8 ? 8 : int'(m_off_bits));
        ib = m_idx_bits > 4'(IDX_MAX) ? IDX_MAX : int'(m_idx_bits);
        set_no = (a.addr >> off) & ((32'd1 << ib) - 32'd1);
        tag = a.addr >> (off + ib);
        blk = (1 << (off - 2)) * cac_pkg::WORD_COST;
        alloc = m_policy < 2'd2;
        wback = m_policy == cac_pkg::WP_ALLOC_BACK;
        is_store = a.op == cac_pkg::OP_STORE;
        hit = 1'b0;
        devict = 1'b0;
        fill = 1'b0;
        way = 0;
        base = set_no * WAYS;
        m_clock = m_clock + 32'd1;
        k_cnt = is_store ? cac_pkg::CNT_STORE : cac_pkg::CNT_LOAD;
        m_stat[k_cnt] = stat_inc(m_stat[k_cnt], 48'd1);
        for (int w = 0; w < WAYS; w++)
            if (!hit && m_valid[base+w] && m_tag[base+w] == tag[cac_pkg::TAG_W-1:0])
            begin
                hit = 1'b1;
                way = w;
            end
        if (hit)
        begin
            cyc = 1;
            if (is_store)
            begin
                if (wback)
                    m_dirty[base+way] = 1'b1;
                else
                    cyc += cac_pkg::WORD_COST;
            end
            m_use[base+way] = m_clock;
            k_cnt = is_store ? cac_pkg::CNT_STORE_HIT : cac_pkg::CNT_LOAD_HIT;
            m_stat[k_cnt] = stat_inc(m_stat[k_cnt], 48'd1);
        end
        else
        begin
            k_cnt = is_store ? cac_pkg::CNT_STORE_MISS : cac_pkg::CNT_LOAD_MISS;
            m_stat[k_cnt] = stat_inc(m_stat[k_cnt], 48'd1);
            if (is_store && !alloc)
                cyc = cac_pkg::WORD_COST + 1;
            else
            begin
                found = 1'b0;
                cyc = 1 + blk;
                for (int w = 0; w < WAYS; w++)
                    if (!found && !m_valid[base+w])
                    begin
                        way = w;
                        found = 1'b1;
                    end
                if (!found)
                begin
                    best = m_lru ? m_use[base] : m_fill[base];
                    way = 0;
                    for (int w = 1; w < WAYS; w++)
                    begin
                        s = m_lru ? m_use[base+w] : m_fill[base+w];
                        if (s < best)
                        begin
                            best = s;
                            way = w;
                        end
                    end
                    if (m_dirty[base+way])
                    begin
                        devict = 1'b1;
                        cyc += blk;
                    end
                end
                fill = 1'b1;
            end
        end
        if (fill)
        begin
            m_valid[base+way] = 1'b1;
            m_tag[base+way] = tag[cac_pkg::TAG_W-1:0];
            m_use[base+way] = m_clock;
            m_fill[base+way] = m_clock;
            m_dirty[base+way] = 1'b0;
            if (is_store)
            begin
                if (wback)
                    m_dirty[base+way] = 1'b1;
                else
                    cyc += cac_pkg::WORD_COST;
            end
        end
        m_stat[cac_pkg::CNT_CYCLES] = stat_inc(m_stat[cac_pkg::CNT_CYCLES], 48'(cyc));
        r.hit = hit;
        r.devict = devict;
        r.cyc = cyc[cac_pkg::CYC_W-1:0];
        r.n_load = m_stat[cac_pkg::CNT_LOAD];
        r.n_store = m_stat[cac_pkg::CNT_STORE];
        r.n_load_hit = m_stat[cac_pkg::CNT_LOAD_HIT];
        r.n_load_miss = m_stat[cac_pkg::CNT_LOAD_MISS];
        r.n_store_hit = m_stat[cac_pkg::CNT_STORE_HIT];
        r.n_store_miss = m_stat[cac_pkg::CNT_STORE_MISS];
        r.n_cycles = m_stat[cac_pkg::CNT_CYCLES];
        return r;
    endfunction

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver
    int unsigned send_gap;
    bit gaps_on;
    always @(negedge clk)
    begin
        if (!in_valid || accepted_now)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_accesses.size() > 0)
            begin
                access_t a;
                a = pending_accesses.pop_front();
                in_valid <= 1'b1;
                opcode <= a.op;
                address <= a.addr;
                send_gap <= gaps_on ? gap_len() : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // set at the rising edge when the current item goes in
    always @(posedge clk)
    begin
        accepted_now <= 1'b0;
        if (rst_n && in_valid && in_ready)
        begin
            expected_outcomes.push_back(cache_access('{op: opcode, addr: address}));
            accepted_now <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            outcome_t got;
            outcome_t want;
            got = '{was_hit, dirty_evicted, access_cycles, load_count, store_count,
                    load_hit_count, load_miss_count, store_hit_count,
                    store_miss_count, cycle_total};
            if (expected_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %p", got);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: expected %p got %p", $realtime, want, got);
                end
            end
        end
    end

    // receiver stalls
    int unsigned recv_gap;
    always @(negedge clk)
    begin
        if (hold_off || recv_gap > 0)
        begin
            out_ready <= 1'b0;
            if (recv_gap > 0)
                recv_gap <= recv_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            recv_gap <= gaps_on ? gap_len() : 0;
        end
    end

    task automatic write_reg(
        logic [cac_pkg::CFG_IDX_W-1:0] idx,
        logic [cac_pkg::CFG_DATA_W-1:0] val
    );
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            cac_pkg::CFG_BLOCK_OFFSET: m_off_bits = val;
            cac_pkg::CFG_SET_INDEX: m_idx_bits = val;
            cac_pkg::CFG_WRITE_POLICY: m_policy = val[1:0];
            default: m_lru = val[0];
        endcase
    endtask

    task automatic drain();
        while (pending_accesses.size() > 0 || in_valid || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic access_t rand_access(int unsigned hot);
        access_t a;
        a.op = 1'($urandom_range(0, 1));
        a.addr = $urandom();
        // confine to few tags so sets fill and hit
        if ($urandom_range(0, 9) < 8)
            a.addr = ($urandom_range(0, hot) << 12) ^ (a.addr & 32'h0000_0FFF);
        return a;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = 1'b0;
        address = '0;
        out_ready = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        gaps_on = 1'b0;
        hold_off = 1'b0;
        accepted_now = 1'b0;
        mismatches = 0;
        m_off_bits = 4'd4;
        m_idx_bits = 4'd8;
        m_policy = cac_pkg::WP_ALLOC_BACK;
        m_lru = 1'b1;
        m_clock = '0;
        for (int i = 0; i < SETS*WAYS; i++)
        begin
            m_valid[i] = 1'b0;
            m_dirty[i] = 1'b0;
            m_tag[i] = '0;
            m_fill[i] = '0;
            m_use[i] = '0;
        end
        for (int i = 0; i < cac_pkg::NUM_STATS; i++)
            m_stat[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, fills, dirty evictions in one set under reset setup
        pending_accesses.push_back('{cac_pkg::OP_LOAD, 32'h0000_0000});
        pending_accesses.push_back('{cac_pkg::OP_STORE, 32'hFFFF_FFFF});
        pending_accesses.push_back('{cac_pkg::OP_LOAD, 32'hFFFF_FFFF});
        pending_accesses.push_back('{cac_pkg::OP_STORE, 32'h0000_0000});
        for (int i = 1; i <= 6; i++)
            pending_accesses.push_back('{cac_pkg::OP_STORE, i << 12});
        pending_accesses.push_back('{cac_pkg::OP_LOAD, 32'h0000_1000});
        pending_accesses.push_back('{cac_pkg::OP_LOAD, 32'h0000_7000});
        drain();

        // fifo, big blocks, one set, write-through; out of range codes too
        write_reg(cac_pkg::CFG_BLOCK_OFFSET, 4'd15);
        write_reg(cac_pkg::CFG_SET_INDEX, 4'd0);
        write_reg(cac_pkg::CFG_WRITE_POLICY, 4'd0);
        write_reg(cac_pkg::CFG_REPLACE_LRU, 4'd0);
        for (int i = 0; i < 7; i++)
            pending_accesses.push_back('{i[0], (i % 5) << 20});
        drain();
        write_reg(cac_pkg::CFG_BLOCK_OFFSET, 4'd0);
        write_reg(cac_pkg::CFG_SET_INDEX, 4'd15);
        write_reg(cac_pkg::CFG_WRITE_POLICY, 4'd3);
        for (int i = 0; i < 6; i++)
            pending_accesses.push_back('{cac_pkg::OP_STORE, i << 4});
        pending_accesses.push_back('{cac_pkg::OP_LOAD, 32'h10});
        drain();

        // random phases over settings
        gaps_on = 1'b1;
        for (int ph = 0; ph < 11; ph++)
        begin
            write_reg(cac_pkg::CFG_BLOCK_OFFSET,
                      ph == 0 ? 4'd2 : (ph == 1 ? 4'd8 : 4'($urandom_range(0, 15))));
            write_reg(cac_pkg::CFG_SET_INDEX,
                      ph == 0 ? 4'd0 : (ph == 1 ? 4'd8 : 4'($urandom_range(0, 15))));
            write_reg(cac_pkg::CFG_WRITE_POLICY, 4'(ph % 4));
            write_reg(cac_pkg::CFG_REPLACE_LRU, 4'(ph % 2));
            for (int i = 0; i < 100; i++)
                pending_accesses.push_back(rand_access(ph < 3 ? 7 : 31));
            if (ph == 4)
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            drain();
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
